[hdl/knot_span_search_unit_defines.svh]
// Assertion macros shared by the knot span search unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef KNOT_SPAN_SEARCH_UNIT_DEFINES_SVH
`define KNOT_SPAN_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define KSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kss check failed");

// next-cycle implication
`define KSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kss check failed");

`endif

[hdl/kss_pkg.sv]
// Types, codes and constants of the knot span search unit.
// No dependencies; imported by every module of the block.
package kss_pkg;

  localparam int KnotW    = 32;
  localparam int SlotW    = 6;
  localparam int MultW    = 7;
  localparam int DegW     = 5;
  localparam int TolW     = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [SlotW-1:0] LastIndexReset = SlotW'(1);
  localparam logic [DegW-1:0]  DegreeReset    = '0;
  localparam logic [TolW-1:0]  ToleranceReset = TolW'(1);

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LAST_INDEX = 2'd0,
    REG_DEGREE     = 2'd1,
    REG_TOLERANCE  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                    func;
    logic [SlotW-1:0]        knot_index;
    logic signed [KnotW-1:0] knot_value;
    logic signed [KnotW-1:0] query_u;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0] span_index;
    logic [MultW-1:0] multiplicity;
    logic             status;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_N,
    ST_CHK_P,
    ST_SEARCH,
    ST_MULT,
    ST_FINISH
  } kss_state_e;

  typedef enum logic [1:0] {
    RD_N,
    RD_P,
    RD_MID,
    RD_IDX
  } rd_sel_e;

  typedef struct packed {
    logic    start;
    logic    set_oor;
    logic    save_ge_n;
    logic    init_bounds;
    logic    step_bounds;
    logic    idx_from_n;
    logic    idx_from_low;
    logic    mult_step;
    rd_sel_e rd_sel;
    logic    load_out;
  } kss_cmd_t;

  typedef struct packed {
    logic is_query;
    logic n_zero;
    logic p_ge_n;
    logic near;
    logic u_lt_k;
    logic ge_n;
    logic gap_init_gt1;
    logic gap_step_gt1;
    logic idx_zero;
  } kss_status_t;

endpackage

[hdl/kss_stream_if.sv]
// Valid/ready channel carrying one payload item of type T.
// No dependencies; payload types come from kss_pkg at instantiation.
interface kss_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/kss_datapath.sv]
// Datapath: config registers, knot memory, search bounds, multiplicity walk.
// Depends on kss_pkg; driven by kss_ctrl through kss_cmd_t.
module kss_datapath import kss_pkg::*; #(
  parameter int KNOT_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_item_i,
  input  logic        cfg_valid_i,
  input  cfg_item_t   cfg_item_i,
  input  kss_cmd_t    cmd_i,
  output kss_status_t status_o,
  output out_item_t   out_item_o
);

  localparam int AddrW = $clog2(KNOT_DEPTH);

  logic [SlotW-1:0] last_index_q;
  logic [DegW-1:0]  degree_q;
  logic [TolW-1:0]  tolerance_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_index_q <= LastIndexReset;
      degree_q     <= DegreeReset;
      tolerance_q  <= ToleranceReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_item_i.index)
        REG_LAST_INDEX: last_index_q <= cfg_item_i.value[SlotW-1:0];
        REG_DEGREE:     degree_q     <= cfg_item_i.value[DegW-1:0];
        REG_TOLERANCE:  tolerance_q  <= cfg_item_i.value[TolW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [KnotW-1:0] mem_q [KNOT_DEPTH];
  logic signed [KnotW-1:0] rdata_q;
  logic                    oob_q;
  logic [SlotW-1:0]        rd_addr;
  logic                    rd_oob;
  logic                    wr_en;

  assign wr_en  = cmd_i.start && (in_item_i.func == FuncWrite) &&
                  (32'(in_item_i.knot_index) < KNOT_DEPTH);
  assign rd_oob = (32'(rd_addr) >= KNOT_DEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AddrW'(in_item_i.knot_index)] <= in_item_i.knot_value;
    end
    rdata_q <= mem_q[AddrW'(rd_addr)];
    oob_q   <= rd_oob;
  end

  logic signed [KnotW-1:0] u_q;
  logic                    ge_n_q;
  logic [SlotW-1:0]        low_q, low_d, upp_q, upp_d, idx_q, idx_d, span_q, span_d;
  logic [MultW-1:0]        mult_q, mult_d;
  logic                    oor_q, oor_d;
  out_item_t               out_q;

  logic signed [KnotW-1:0] knot;
  logic signed [KnotW:0]   diff;
  logic [KnotW:0]          adiff;
  logic [TolW-1:0]         tol_eff;
  logic [SlotW-1:0]        p_ext, gap_init, mid_cur, low_step, upp_step, gap_step, mid_next;
  logic [SlotW:0]          sum_cur, sum_next;

  assign knot    = oob_q ? '0 : rdata_q;
  assign diff    = {u_q[KnotW-1], u_q} - {knot[KnotW-1], knot};
  assign adiff   = diff[KnotW] ? (KnotW+1)'(-diff) : (KnotW+1)'(diff);
  assign tol_eff = (tolerance_q == '0) ? TolW'(1) : tolerance_q;

  assign p_ext    = {1'b0, degree_q};
  assign gap_init = last_index_q - p_ext;
  assign sum_cur  = {1'b0, low_q} + {1'b0, upp_q};
  assign mid_cur  = sum_cur[SlotW:1];
  assign low_step = (u_q < knot) ? low_q : mid_cur;
  assign upp_step = (u_q < knot) ? mid_cur : upp_q;
  assign gap_step = upp_step - low_step;

  always_comb begin
    low_d = low_q;
    upp_d = upp_q;
    if (cmd_i.init_bounds) begin
      low_d = p_ext;
      upp_d = last_index_q;
    end else if (cmd_i.step_bounds) begin
      low_d = low_step;
      upp_d = upp_step;
    end
  end

  assign sum_next = {1'b0, low_d} + {1'b0, upp_d};
  assign mid_next = sum_next[SlotW:1];

  always_comb begin
    idx_d  = idx_q;
    span_d = span_q;
    mult_d = mult_q;
    oor_d  = oor_q;
    if (cmd_i.start) begin
      span_d = '0;
      mult_d = '0;
      oor_d  = 1'b0;
    end
    if (cmd_i.set_oor) begin
      oor_d = 1'b1;
    end
    if (cmd_i.idx_from_n) begin
      idx_d  = last_index_q - SlotW'(1);
      span_d = idx_d;
    end else if (cmd_i.idx_from_low) begin
      idx_d  = low_d;
      span_d = idx_d;
    end else if (cmd_i.mult_step) begin
      idx_d  = idx_q - SlotW'(1);
      mult_d = mult_q + MultW'(1);
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_N:    rd_addr = last_index_q;
      RD_P:    rd_addr = p_ext;
      RD_MID:  rd_addr = mid_next;
      RD_IDX:  rd_addr = idx_d;
      default: rd_addr = last_index_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      u_q <= in_item_i.query_u;
    end
    if (cmd_i.save_ge_n) begin
      ge_n_q <= !(u_q < knot);
    end
    low_q  <= low_d;
    upp_q  <= upp_d;
    idx_q  <= idx_d;
    span_q <= span_d;
    mult_q <= mult_d;
    oor_q  <= oor_d;
    if (cmd_i.load_out) begin
      out_q.span_index   <= span_q;
      out_q.multiplicity <= mult_q;
      out_q.status       <= oor_q;
    end
  end

  assign status_o.is_query     = (in_item_i.func == FuncQuery);
  assign status_o.n_zero       = (last_index_q == '0);
  assign status_o.p_ge_n       = (p_ext >= last_index_q);
  assign status_o.near         = (adiff < (KnotW+1)'(tol_eff));
  assign status_o.u_lt_k       = (u_q < knot);
  assign status_o.ge_n         = ge_n_q;
  assign status_o.gap_init_gt1 = (gap_init > SlotW'(1));
  assign status_o.gap_step_gt1 = (gap_step > SlotW'(1));
  assign status_o.idx_zero     = (idx_q == '0);

  assign out_item_o = out_q;

endmodule

[hdl/kss_ctrl.sv]
// Controller: sequences range checks, bisection and multiplicity walk.
// Depends on kss_pkg and knot_span_search_unit_defines.svh.
`include "knot_span_search_unit_defines.svh"
module kss_ctrl import kss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  kss_status_t status_i,
  output kss_cmd_t    cmd_o
);

  kss_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = status_i.is_query ? ST_CHK_N : ST_FINISH;
      end
      ST_CHK_N: begin
        priority if (status_i.n_zero) state_d = ST_FINISH;
        else if (status_i.near)       state_d = ST_MULT;
        else if (status_i.p_ge_n)     state_d = ST_FINISH;
        else                          state_d = ST_CHK_P;
      end
      ST_CHK_P: begin
        priority if (status_i.u_lt_k || status_i.ge_n) state_d = ST_FINISH;
        else if (status_i.gap_init_gt1)                state_d = ST_SEARCH;
        else                                           state_d = ST_MULT;
      end
      ST_SEARCH: begin
        if (!status_i.gap_step_gt1) state_d = ST_MULT;
      end
      ST_MULT: begin
        if (!status_i.near || status_i.idx_zero) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_N;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.start = in_fire;
      end
      ST_CHK_N: begin
        priority if (status_i.n_zero) begin
          cmd_o.set_oor = 1'b1;
        end else if (status_i.near) begin
          cmd_o.idx_from_n = 1'b1;
          cmd_o.rd_sel     = RD_IDX;
        end else if (status_i.p_ge_n) begin
          cmd_o.set_oor = 1'b1;
        end else begin
          cmd_o.save_ge_n = 1'b1;
          cmd_o.rd_sel    = RD_P;
        end
      end
      ST_CHK_P: begin
        priority if (status_i.u_lt_k || status_i.ge_n) begin
          cmd_o.set_oor = 1'b1;
        end else if (status_i.gap_init_gt1) begin
          cmd_o.init_bounds = 1'b1;
          cmd_o.rd_sel      = RD_MID;
        end else begin
          cmd_o.init_bounds  = 1'b1;
          cmd_o.idx_from_low = 1'b1;
          cmd_o.rd_sel       = RD_IDX;
        end
      end
      ST_SEARCH: begin
        cmd_o.step_bounds = 1'b1;
        if (status_i.gap_step_gt1) begin
          cmd_o.rd_sel = RD_MID;
        end else begin
          cmd_o.idx_from_low = 1'b1;
          cmd_o.rd_sel       = RD_IDX;
        end
      end
      ST_MULT: begin
        cmd_o.mult_step = status_i.near;
        cmd_o.rd_sel    = RD_IDX;
      end
      ST_FINISH: begin
        cmd_o.load_out = out_free;
      end
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `KSS_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_fire, state_q != ST_IDLE)
  `KSS_ASSERT_IMPL(a_load_when_free, clk_i, rst_ni, cmd_o.load_out, !out_valid_q || out_ready_i)
  `KSS_ASSERT_NEXT(a_search_exit, clk_i, rst_ni, state_q == ST_SEARCH, state_q == ST_SEARCH || state_q == ST_MULT)
  `KSS_ASSERT_NEXT(a_mult_miss_ends, clk_i, rst_ni, state_q == ST_MULT && !status_i.near, state_q == ST_FINISH)

endmodule

[hdl/knot_span_search_unit.sv]
// Knot span search unit: knot table with span search and multiplicity count.
// Usage:
//   in_i  : valid/ready item channel. func=0 stores knot_value at knot_index,
//           func=1 searches query_u. Taken only while the unit is idle.
//   out_o : one result item per input item (span_index, multiplicity, status);
//           writes return all zeros, an out-of-range query returns status 1.
//   cfg_i : register writes (0 last_index, 1 degree, 2 tolerance), always
//           ready; write only while no item is in flight.
// Sequencing: a write goes straight to ST_FINISH, which loads the output
//   register. A query checks knot[n], then knot[p], runs S bisection steps (S at
//   most ceil(log2(n - p)), six for 64 knots) and then the multiplicity walk;
//   a query near knot[n] skips to the walk, an out-of-range query ends after
//   either check. Each step is one read of the single-port knot memory with
//   registered read data. The next item is taken only once the unit is idle.
// Reset: registers return to last_index 1, degree 0, tolerance 1; knot table
//   contents are undefined until written.
// A result waits in the output register while out_o is stalled; the next
//   item is accepted meanwhile and holds its result until the register frees.
// Depends on kss_pkg, kss_stream_if, kss_ctrl and kss_datapath.
module knot_span_search_unit import kss_pkg::*; #(
  parameter int KNOT_DEPTH = 64
) (
  input logic          clk_i,
  input logic          rst_ni,
  kss_stream_if.sink   in_i,
  kss_stream_if.source out_o,
  kss_stream_if.sink   cfg_i
);

  kss_cmd_t    cmd;
  kss_status_t status;
  logic        in_ready;
  logic        out_valid;
  out_item_t   out_item;

  kss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kss_datapath #(
    .KNOT_DEPTH (KNOT_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_item_i  (cfg_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_item;

endmodule

[bench/knot_span_search_unit_test.sv]
`timescale 1ns / 100ps
// Testbench for knot_span_search_unit: knot writes, span queries and register settings.
// Results are checked against a local span/multiplicity predictor under random stalls.
// Depends on kss_pkg, kss_stream_if and knot_span_search_unit.
module knot_span_search_unit_test;
  import kss_pkg::*;

  localparam int     KnotDepth    = 64;
  localparam int     SettleCycles = 10;
  localparam int     FinalCycles  = 100;
  localparam int     CycleLimit   = 600000;
  localparam longint Q16Max       = 64'sd2147483647;
  localparam longint Q16Min       = -64'sd2147483648;

  logic clk;
  logic rst_n;

  kss_stream_if #(.T(in_item_t))  knot_if ();
  kss_stream_if #(.T(out_item_t)) res_if ();
  kss_stream_if #(.T(cfg_item_t)) cfg_if ();

  knot_span_search_unit #(.KNOT_DEPTH(KnotDepth)) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (knot_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  logic signed [KnotW-1:0] knot_mirror [KnotDepth];
  logic [SlotW-1:0]        cur_last;
  logic [DegW-1:0]         cur_degree;
  logic [TolW-1:0]         cur_tol;
  out_item_t               span_expect_q [$];

  bit send_gaps   = 1'b1;
  bit recv_stalls = 1'b1;
  int result_hold = 0;
  int error_count = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** knot_span_search_unit: FAILED **");
    $finish;
  end

  function automatic bit knot_near(logic signed [KnotW-1:0] k, logic signed [KnotW-1:0] u);
    longint d;
    longint t;
    d = longint'(u) - longint'(k);
    if (d < 0) d = -d;
    t = (cur_tol == '0) ? 1 : longint'(cur_tol);
    return d < t;
  endfunction

  // Applies one item to the mirror and returns the result it must produce.
  function automatic out_item_t predict_span(in_item_t item);
    out_item_t               res;
    logic signed [KnotW-1:0] u;
    int                      n, p, lo, hi, mid, span, idx, mult;
    res = '0;
    if (item.func == FuncWrite) begin
      knot_mirror[item.knot_index] = item.knot_value;
      return res;
    end
    u = item.query_u;
    n = int'(cur_last);
    p = int'(cur_degree);
    if (n == 0) begin
      res.status = 1'b1;
      return res;
    end
    if (knot_near(knot_mirror[n], u)) begin
      span = n - 1;
    end else begin
      if (p >= n || u < knot_mirror[p] || u >= knot_mirror[n]) begin
        res.status = 1'b1;
        return res;
      end
      lo = p;
      hi = n;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (u < knot_mirror[mid]) hi = mid;
        else lo = mid;
      end
      span = lo;
    end
    mult = 0;
    idx = span;
    while (knot_near(knot_mirror[idx], u)) begin
      mult++;
      if (idx == 0) break;
      idx--;
    end
    res.span_index   = SlotW'(span);
    res.multiplicity = MultW'(mult);
    return res;
  endfunction

  function automatic logic signed [KnotW-1:0] clamp_q16(longint v);
    if (v > Q16Max) return KnotW'(Q16Max);
    if (v < Q16Min) return KnotW'(Q16Min);
    return v[KnotW-1:0];
  endfunction

  function automatic in_item_t knot_write(int slot, logic signed [KnotW-1:0] val);
    in_item_t item;
    item.func       = FuncWrite;
    item.knot_index = slot[SlotW-1:0];
    item.knot_value = val;
    item.query_u    = $urandom;
    return item;
  endfunction

  function automatic in_item_t span_query(logic signed [KnotW-1:0] u);
    in_item_t item;
    item.func       = FuncQuery;
    item.knot_index = $urandom;
    item.knot_value = $urandom;
    item.query_u    = u;
    return item;
  endfunction

  // Mostly parameters near knots or inside [knot[p], knot[n]], some outside.
  function automatic logic signed [KnotW-1:0] pick_query_u();
    int     n, p, lo_idx, j, t;
    longint a, b, v;
    n      = int'(cur_last);
    p      = int'(cur_degree);
    t      = int'(cur_tol);
    lo_idx = (p < n) ? p : n;
    j      = $urandom_range(n, lo_idx);
    a      = longint'(knot_mirror[lo_idx]);
    b      = longint'(knot_mirror[n]);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = longint'(knot_mirror[j]) + longint'($urandom_range(2 * t + 4)) - (t + 2);
      5, 6:          v = (b > a) ? a + longint'($urandom) % (b - a) : a;
      7:             v = b + longint'($urandom_range(2)) - 1;
      8:             v = (a - 1) - longint'($urandom_range(t + 16));
      default:       v = longint'($signed($urandom));
    endcase
    return clamp_q16(v);
  endfunction

  task automatic report_error(string what, out_item_t want, out_item_t got);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s: expected span %0d mult %0d status %0b, got span %0d mult %0d status %0b",
               $time, what, want.span_index, want.multiplicity, want.status,
               got.span_index, got.multiplicity, got.status);
  endtask

  initial begin : result_check
    out_item_t want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        if (span_expect_q.size() == 0) begin
          report_error("result without pending item", '0, res_if.data);
        end else begin
          want = span_expect_q.pop_front();
          if (res_if.data.span_index !== want.span_index ||
              res_if.data.multiplicity !== want.multiplicity ||
              res_if.data.status !== want.status)
            report_error("result mismatch", want, res_if.data);
        end
      end
      if (result_hold > 0) begin
        res_if.ready <= 1'b0;
        result_hold--;
      end else begin
        res_if.ready <= !(recv_stalls && $urandom_range(99) < 31);
      end
    end
  end

  task automatic send_item(in_item_t item);
    while (send_gaps && $urandom_range(99) < 31) begin
      knot_if.valid <= 1'b0;
      @(posedge clk);
    end
    knot_if.valid <= 1'b1;
    knot_if.data  <= item;
    @(posedge clk);
    while (!knot_if.ready) @(posedge clk);
    span_expect_q.push_back(predict_span(item));
  endtask

  task automatic drain_results(int cycles);
    knot_if.valid <= 1'b0;
    while (span_expect_q.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_LAST_INDEX: cur_last   = val[SlotW-1:0];
      REG_DEGREE:     cur_degree = val[DegW-1:0];
      REG_TOLERANCE:  cur_tol    = val[TolW-1:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry random values.
  task automatic set_config(int n, int p, int t);
    write_reg(REG_LAST_INDEX, {10'($urandom), 6'(n)});
    write_reg(REG_DEGREE, {11'($urandom), 5'(p)});
    write_reg(REG_TOLERANCE, 16'(t));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(knot_write(0, 32'sh0000_0000));
    send_item(knot_write(1, 32'sh0001_0000));
    send_item(span_query(32'sh0000_8000));
    send_item(span_query(32'sh0001_0000));
    send_item(span_query(32'sh0001_8000));
  endtask

  task automatic test_extreme_knots();
    drain_results(SettleCycles);
    set_config(5, 2, 0);
    send_item(knot_write(0, 32'sh8000_0000));
    send_item(knot_write(1, 32'shFFFF_0000));
    send_item(knot_write(2, 32'sh0000_0000));
    send_item(knot_write(3, 32'sh0000_0000));
    send_item(knot_write(4, 32'sh0001_0000));
    send_item(knot_write(5, 32'sh7FFF_FFFF));
    send_item(knot_write(63, 32'sh7FFF_FFFF));
    send_item(span_query(32'sh0000_0000));
    send_item(span_query(32'sh7FFF_FFFF));
    send_item(span_query(32'sh8000_0000));
    send_item(span_query(32'sh7FFF_FFFE));
    send_item(span_query(32'shFFFF_FFFF));
  endtask

  task automatic test_degenerate_config();
    drain_results(SettleCycles);
    set_config(3, 3, 1);
    send_item(span_query(32'sh0000_0000));
    drain_results(SettleCycles);
    set_config(0, 0, 1);
    send_item(span_query(32'sh0000_0000));
    drain_results(SettleCycles);
    set_config(5, 0, 16'hFFFF);
    send_item(span_query(32'sh0000_8000));
  endtask

  task automatic test_random_spans();
    int                      n, p, t, slot;
    longint                  acc, lo_k, hi_k;
    logic signed [KnotW-1:0] val;
    for (int rnd = 0; rnd < 10; rnd++) begin
      drain_results(SettleCycles);
      case (rnd)
        0: begin n = 63; p = 3;  t = $urandom_range(16'h0200); end
        1: begin n = 63; p = 0;  t = 0; end
        2: begin n = 1;  p = 0;  t = 16'hFFFF; end
        3: begin n = 63; p = 31; t = 1; end
        5: begin n = 0;  p = 0;  t = $urandom_range(16'hFFFF); end
        default: begin
          n = $urandom_range(63, 1);
          p = $urandom_range((n < 31) ? n : 31, 0);
          case ($urandom_range(3))
            0:       t = 0;
            1:       t = 16'hFFFF;
            2:       t = $urandom_range(16'h0400, 1);
            default: t = $urandom_range(16'hFFFF);
          endcase
        end
      endcase
      set_config(n, p, t);

      // full table: sorted with repeated knots, or unordered in round 4
      if (rnd == 0 || rnd == 4 || rnd == 7) begin
        acc = longint'($signed($urandom)) >>> 2;
        if (rnd == 7) acc = Q16Min + longint'($urandom_range(16'h03FF));
        for (int s = 0; s < KnotDepth; s++) begin
          if (rnd == 4) begin
            val = $urandom;
          end else begin
            case ($urandom_range(3))
              0:       ;
              1:       acc += $urandom_range(32'h0000_FFFF);
              2:       acc += $urandom_range(32'h00FF_FFFF);
              default: acc += $urandom_range(32'h07FF_FFFF);
            endcase
            val = clamp_q16(acc);
          end
          send_item(knot_write(s, val));
        end
      end

      if (rnd == 8) begin
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
      end
      repeat ((n == 0) ? 8 : 44) begin
        if ($urandom_range(9) == 0) begin
          slot = $urandom_range(KnotDepth - 1);
          lo_k = longint'(knot_mirror[(slot == 0) ? 0 : slot - 1]);
          hi_k = longint'(knot_mirror[(slot == KnotDepth - 1) ? slot : slot + 1]);
          if (hi_k >= lo_k && $urandom_range(4) != 0)
            val = clamp_q16(lo_k + longint'($urandom) % (hi_k - lo_k + 1));
          else
            val = $urandom;
          send_item(knot_write(slot, val));
        end else begin
          send_item(span_query(pick_query_u()));
        end
      end
      send_gaps   = 1'b1;
      recv_stalls = 1'b1;
    end
  endtask

  // Output held off long enough for the unit to stall its input.
  task automatic test_output_backpressure();
    drain_results(SettleCycles);
    send_gaps   = 1'b0;
    result_hold = 300;
    repeat (12) send_item(span_query(pick_query_u()));
    drain_results(SettleCycles);
    send_gaps = 1'b1;
  endtask

  initial begin : stimulus
    rst_n         <= 1'b0;
    knot_if.valid <= 1'b0;
    knot_if.data  <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '0;
    cur_last   = LastIndexReset;
    cur_degree = DegreeReset;
    cur_tol    = ToleranceReset;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extreme_knots();
    test_degenerate_config();
    test_random_spans();
    test_output_backpressure();

    drain_results(FinalCycles);
    if (error_count == 0)
      $display("** knot_span_search_unit: PASSED **");
    else
      $display("** knot_span_search_unit: FAILED **");
    $finish;
  end

endmodule
